>>> sv/rmfn_pkg.sv
// shared constants and types for the register mapped frame nic
// register offsets, command codes, frame limits and the result record
package rmfn_pkg;

  localparam int FRAME_MAX = 1514;
  localparam int CNT_W     = 11;
  localparam int STORE_AW  = $clog2(FRAME_MAX);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] FRAME_LIM = CNT_W'(FRAME_MAX);

  localparam logic [31:0] ID_WORD0 = 32'h5350494d;
  localparam logic [31:0] ID_WORD1 = 32'h3054454e;
  localparam logic [31:0] TEST_BIT = 32'h80000000;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RXB   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [5:0] REG_ID0    = 6'h00;
  localparam logic [5:0] REG_ID1    = 6'h04;
  localparam logic [5:0] REG_BUSY   = 6'h08;
  localparam logic [5:0] REG_AVAIL  = 6'h0c;
  localparam logic [5:0] REG_TXLEN  = 6'h10;
  localparam logic [5:0] REG_INTR   = 6'h14;
  localparam logic [5:0] REG_RXDATA = 6'h1c;
  localparam logic [5:0] REG_TXDATA = 6'h20;

  localparam int FLAG_TXDONE = 0;
  localparam int FLAG_RXDONE = 1;
  localparam int FLAG_TEST   = 2;

  typedef struct packed {
    logic [31:0] rdata;
    logic        rxrd;
    logic        irq;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        tx_abort;
    logic        rx_refused;
  } result_t;

endpackage

>>> sv/rmfn_rx_store.sv
// receive frame store: one write port, one registered read port
// depends on rmfn_pkg for depth and address width
module rmfn_rx_store
  import rmfn_pkg::*;
(
  input  logic                clk,
  input  logic                we,
  input  logic [STORE_AW-1:0] waddr,
  input  logic [7:0]          wbyte,
  input  logic                re,
  input  logic [STORE_AW-1:0] raddr,
  output logic [7:0]          rbyte
);

  logic [7:0] mem [FRAME_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wbyte;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rbyte <= mem[raddr];
    end
  end

endmodule

>>> sv/register_mapped_frame_nic.sv
// path: an accepted item is registered in stage one, then in the output register
// throughput: one item per cycle while rsp_stall does not hold the output; the
// store read is issued at accept and joins the result in the following stage
// reset: synchronous, busy set, counts, indexes and flags cleared; the frame
// store is not cleared, since only written entries are ever read
// depends on rmfn_pkg and rmfn_rx_store
module register_mapped_frame_nic
  import rmfn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  cmd,
  input  logic [5:0]  addr,
  input  logic [31:0] wdata,
  input  logic [7:0]  rx_byte,
  input  logic        rx_last,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] rdata,
  output logic        irq,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic        tx_abort,
  output logic        rx_refused
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_STORE = 2'd1,
    PH_DROP  = 2'd2
  } phase_t;

  logic             busy_flag, busy_flag_next;
  logic [2:0]       int_flags, int_flags_next;
  logic [CNT_W-1:0] rx_avail, rx_avail_next;
  logic [CNT_W-1:0] rx_rd_index, rx_rd_index_next;
  logic [CNT_W-1:0] rx_fill_index, rx_fill_index_next;
  phase_t           rx_phase, rx_phase_next;
  logic [CNT_W-1:0] tx_length, tx_length_next;
  logic [CNT_W-1:0] tx_done_count, tx_done_count_next;

  logic             req_acc, s1_adv;
  logic             s1_valid;
  result_t          s1, res;
  logic             mem_we, mem_re;
  logic [CNT_W-1:0] mem_waddr;
  logic [7:0]       mem_rbyte;

  logic [CNT_W-1:0] fill_base, cnt_inc;
  logic [2:0]       flags_ack;

  assign s1_adv    = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !s1_adv;
  assign req_acc   = req_valid && !req_stall;

  always_comb begin
    busy_flag_next     = busy_flag;
    int_flags_next     = int_flags;
    rx_avail_next      = rx_avail;
    rx_rd_index_next   = rx_rd_index;
    rx_fill_index_next = rx_fill_index;
    rx_phase_next      = rx_phase;
    tx_length_next     = tx_length;
    tx_done_count_next = tx_done_count;
    res                = '0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_waddr          = rx_fill_index;
    fill_base          = rx_fill_index;
    flags_ack          = int_flags;
    cnt_inc            = (tx_done_count < CNT_MAX) ? tx_done_count + 1'b1 : tx_done_count;

    unique case (cmd_t'(cmd))
      CMD_READ: begin
        unique case (addr)
          REG_ID0:   res.rdata = ID_WORD0;
          REG_ID1:   res.rdata = ID_WORD1;
          REG_BUSY:  res.rdata = {31'd0, busy_flag};
          REG_AVAIL: res.rdata = 32'(rx_avail);
          REG_TXLEN: res.rdata = 32'(tx_length);
          REG_INTR: begin
            res.rdata = (int_flags[FLAG_TEST] ? TEST_BIT : 32'd0)
                      | {30'd0, int_flags[FLAG_RXDONE], int_flags[FLAG_TXDONE]};
            int_flags_next[FLAG_TEST] = 1'b0;
          end
          REG_RXDATA: begin
            if (rx_avail != '0) begin
              rx_avail_next = rx_avail - 1'b1;
              res.rxrd      = (rx_rd_index < FRAME_LIM);
              mem_re        = res.rxrd;
              if (rx_rd_index < CNT_MAX) begin
                rx_rd_index_next = rx_rd_index + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_WRITE: begin
        unique case (addr)
          REG_TXLEN: begin
            res.tx_abort       = (tx_done_count != '0);
            tx_length_next     = (wdata <= 32'(FRAME_MAX)) ? wdata[CNT_W-1:0] : '0;
            tx_done_count_next = '0;
          end
          REG_INTR: begin
            // acknowledge by priority: txdone, then rxdone, then soft reset
            if (wdata[0]) begin
              flags_ack[FLAG_TXDONE] = 1'b0;
            end else if (wdata[1]) begin
              flags_ack[FLAG_RXDONE] = 1'b0;
            end else if (wdata[31]) begin
              res.tx_abort       = (tx_done_count != '0);
              rx_avail_next      = '0;
              rx_rd_index_next   = '0;
              rx_fill_index_next = '0;
              if (rx_phase == PH_STORE) begin
                rx_phase_next = PH_DROP;
              end
              tx_length_next     = '0;
              tx_done_count_next = '0;
              flags_ack          = 3'b100;
            end
            int_flags_next = flags_ack;
            busy_flag_next = (flags_ack != '0);
          end
          REG_TXDATA: begin
            res.tx_valid = 1'b1;
            res.tx_byte  = wdata[7:0];
            if (tx_length != '0 && cnt_inc == tx_length) begin
              res.tx_last                 = 1'b1;
              tx_length_next              = '0;
              tx_done_count_next          = '0;
              int_flags_next[FLAG_TXDONE] = 1'b1;
              busy_flag_next              = 1'b1;
            end else begin
              tx_done_count_next = cnt_inc;
            end
          end
          default: ;
        endcase
      end
      CMD_RXB: begin
        case (rx_phase)
          PH_IDLE: begin
            if (busy_flag || rx_avail >= FRAME_LIM) begin
              res.rx_refused = 1'b1;
              if (!rx_last) begin
                rx_phase_next = PH_DROP;
              end
            end else begin
              busy_flag_next   = 1'b1;
              rx_avail_next    = '0;
              rx_rd_index_next = '0;
              fill_base        = '0;
              rx_phase_next    = PH_STORE;
            end
          end
          PH_DROP: begin
            if (rx_last) begin
              rx_phase_next = PH_IDLE;
            end
          end
          default: ;
        endcase
        if (rx_phase_next == PH_STORE) begin
          rx_fill_index_next = fill_base;
          mem_waddr          = fill_base;
          // bytes past the frame limit are dropped
          if (fill_base < FRAME_LIM) begin
            mem_we             = 1'b1;
            rx_fill_index_next = fill_base + 1'b1;
          end
          if (rx_last) begin
            rx_avail_next               = rx_fill_index_next;
            rx_rd_index_next            = '0;
            int_flags_next[FLAG_RXDONE] = 1'b1;
            rx_phase_next               = PH_IDLE;
          end
        end
      end
      default: ;
    endcase

    res.irq = (int_flags_next != '0);
  end

  rmfn_rx_store u_store (
    .clk   (clk),
    .we    (mem_we && req_acc),
    .waddr (mem_waddr[STORE_AW-1:0]),
    .wbyte (rx_byte),
    .re    (mem_re && req_acc),
    .raddr (rx_rd_index[STORE_AW-1:0]),
    .rbyte (mem_rbyte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag     <= 1'b1;
      int_flags     <= '0;
      rx_avail      <= '0;
      rx_rd_index   <= '0;
      rx_fill_index <= '0;
      rx_phase      <= PH_IDLE;
      tx_length     <= '0;
      tx_done_count <= '0;
    end else if (req_acc) begin
      busy_flag     <= busy_flag_next;
      int_flags     <= int_flags_next;
      rx_avail      <= rx_avail_next;
      rx_rd_index   <= rx_rd_index_next;
      rx_fill_index <= rx_fill_index_next;
      rx_phase      <= rx_phase_next;
      tx_length     <= tx_length_next;
      tx_done_count <= tx_done_count_next;
    end
  end

  // stage one waits on the store read, the output register parts the sides
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1 <= res;
    end
    if (s1_valid && s1_adv) begin
      rdata      <= s1.rxrd ? {24'd0, mem_rbyte} : s1.rdata;
      irq        <= s1.irq;
      tx_valid   <= s1.tx_valid;
      tx_byte    <= s1.tx_byte;
      tx_last    <= s1.tx_last;
      tx_abort   <= s1.tx_abort;
      rx_refused <= s1.rx_refused;
    end
  end

  // read pointer plus bytes left always meets the fill point outside a frame
  a_rx_count: assert property (@(posedge clk) disable iff (rst)
    rx_phase != PH_STORE |->
      ({1'b0, rx_rd_index} + {1'b0, rx_avail}) == {1'b0, rx_fill_index})
    else $error("receive counts out of step");

  a_rd_pending: assert property (@(posedge clk) disable iff (rst)
    req_acc && mem_re |=> s1_valid && s1.rxrd)
    else $error("store read lost its stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1) && $stable(mem_rbyte))
    else $error("stalled stage changed");

  a_tx_last: assert property (@(posedge clk) disable iff (rst)
    req_acc && res.tx_last |=>
      tx_done_count == '0 && tx_length == '0 && busy_flag && int_flags[FLAG_TXDONE])
    else $error("frame end left transmit state");

endmodule
